@@ rtl/core/rvc_pkg.sv @@
// rvc_pkg: shared types and constants of the running-shift vigenere cipher unit
`default_nettype none
package rvc_pkg;

  localparam int unsigned ALPHA_LEN   = 26;
  localparam int unsigned LETTER_W    = 5;
  localparam int unsigned KEY_HALF_W  = 60;
  localparam int unsigned CFG_DATA_W  = 60;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CHAR_W      = 8;

  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CIPHER_MODE = 2'd0,
    REG_KEY_LENGTH  = 2'd1,
    REG_KEY_LOW     = 2'd2,
    REG_KEY_HIGH    = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    MODE_ENCRYPT = 1'b0,
    MODE_DECRYPT = 1'b1
  } cipher_mode_e;

  typedef struct packed {
    cipher_mode_e              mode;
    logic [LETTER_W-1:0]       key_length;
    logic [KEY_HALF_W-1:0]     key_low;
    logic [KEY_HALF_W-1:0]     key_high;
  } cfg_t;

  typedef struct packed {
    logic [LETTER_W-1:0] position_mod;
    logic [LETTER_W-1:0] key_index;
    logic [LETTER_W-1:0] running_shift;
  } ks_state_t;

endpackage
`default_nettype wire

@@ rtl/core/rvc_if.sv @@
// rvc_if: valid/ready stream interfaces for input and result beats
`default_nettype none
interface rvc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       start_of_message;

  modport source (output valid, output char_in, output start_of_message, input ready);
  modport sink   (input valid, input char_in, input start_of_message, output ready);
endinterface

interface rvc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;

  modport source (output valid, output char_out, input ready);
  modport sink   (input valid, input char_out, output ready);
endinterface
`default_nettype wire

@@ rtl/core/rvc_cfg_regs.sv @@
// rvc_cfg_regs: configuration register bank written through the plain write port
`default_nettype none
module rvc_cfg_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [rvc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [rvc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output rvc_pkg::cfg_t                          cfg_o
);

  rvc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (rvc_pkg::cfg_reg_e'(cfg_idx_i))
        rvc_pkg::REG_CIPHER_MODE: cfg_d.mode       = rvc_pkg::cipher_mode_e'(cfg_data_i[0]);
        rvc_pkg::REG_KEY_LENGTH:  cfg_d.key_length = cfg_data_i[rvc_pkg::LETTER_W-1:0];
        rvc_pkg::REG_KEY_LOW:     cfg_d.key_low    = cfg_data_i[rvc_pkg::KEY_HALF_W-1:0];
        rvc_pkg::REG_KEY_HIGH:    cfg_d.key_high   = cfg_data_i[rvc_pkg::KEY_HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= rvc_pkg::MODE_ENCRYPT;
      cfg_q.key_length <= rvc_pkg::LETTER_W'(1);
      cfg_q.key_low    <= '0;
      cfg_q.key_high   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ rtl/core/rvc_xform.sv @@
// rvc_xform: one-byte cipher transform and next keystream state
`default_nettype none
module rvc_xform #(
  parameter int unsigned MAX_KEY_LEN = 24
) (
  input  wire logic [rvc_pkg::CHAR_W-1:0] char_i,
  input  wire logic                       start_i,
  input  wire rvc_pkg::cfg_t              cfg_i,
  input  wire rvc_pkg::ks_state_t         state_i,
  output logic [rvc_pkg::CHAR_W-1:0]      char_o,
  output rvc_pkg::ks_state_t              state_o
);

  localparam int unsigned LW = rvc_pkg::LETTER_W;
  localparam logic [LW-1:0] KeyLenMax = LW'(MAX_KEY_LEN);
  localparam logic [6:0] Mod1 = 7'(rvc_pkg::ALPHA_LEN);
  localparam logic [6:0] Mod2 = 7'(2 * rvc_pkg::ALPHA_LEN);
  localparam logic [6:0] Mod3 = 7'(3 * rvc_pkg::ALPHA_LEN);

  // reduce a value below four alphabets back into 0..25
  function automatic logic [LW-1:0] mod26(input logic [6:0] x);
    logic [6:0] r;
    if (x >= Mod3)      r = x - Mod3;
    else if (x >= Mod2) r = x - Mod2;
    else if (x >= Mod1) r = x - Mod1;
    else                r = x;
    return r[LW-1:0];
  endfunction

  rvc_pkg::ks_state_t         cur;
  logic [LW-1:0]              len, idx, key_letter, shift, v, r, cipher_val;
  logic [2*rvc_pkg::KEY_HALF_W-1:0] key_all;
  logic                       upper, lower;
  logic [rvc_pkg::CHAR_W-1:0] base;

  always_comb begin
    cur = start_i ? '0 : state_i;

    if (cfg_i.key_length == '0)            len = LW'(1);
    else if (cfg_i.key_length > KeyLenMax) len = KeyLenMax;
    else                                   len = cfg_i.key_length;

    idx = (cur.key_index < len) ? cur.key_index : '0;

    key_all    = {cfg_i.key_high, cfg_i.key_low};
    key_letter = key_all[idx*LW +: LW];

    upper = (char_i >= rvc_pkg::CHAR_UPPER_A) && (char_i <= rvc_pkg::CHAR_UPPER_Z);
    lower = (char_i >= rvc_pkg::CHAR_LOWER_A) && (char_i <= rvc_pkg::CHAR_LOWER_Z);
    base  = upper ? rvc_pkg::CHAR_UPPER_A : rvc_pkg::CHAR_LOWER_A;
    v     = LW'(char_i - base);

    shift = mod26(7'(key_letter) + 7'(cur.running_shift) + 7'(cur.position_mod));

    if (cfg_i.mode == rvc_pkg::MODE_ENCRYPT) begin
      r          = mod26(7'(v) + 7'(shift));
      cipher_val = r;
    end else begin
      r          = mod26(7'(v) + Mod1 - 7'(shift));
      cipher_val = v;
    end

    state_o = cur;
    char_o  = char_i;
    if (upper || lower) begin
      char_o                = base + rvc_pkg::CHAR_W'(r);
      state_o.running_shift = mod26(7'(cur.running_shift) + 7'(cipher_val));
    end

    state_o.position_mod = (7'(cur.position_mod) + 7'd1 >= Mod1) ? '0
                                                                 : cur.position_mod + LW'(1);
    state_o.key_index    = (idx + LW'(1) >= len) ? '0 : idx + LW'(1);
  end

endmodule
`default_nettype wire

@@ rtl/core/running_shift_vigenere_cipher_unit.sv @@
// running_shift_vigenere_cipher_unit: top level of the running-shift vigenere byte cipher
//
//   channel   dir  handshake     payload
//   in_i      in   valid/ready   char_in[7:0], start_of_message
//   out_o     out  valid/ready   char_out[7:0]
//   cfg_*     in   cfg_we_i      cfg_idx_i[1:0], cfg_data_i[59:0]
//
// one byte per cycle sustained while out_o is ready; a beat is held in the input register
// and then in the result register before it leaves
// keystream state (position, key index, running shift) updates as a byte moves
// from the input register into the result register
// a stalled result holds the pipe; the input register still fills behind it
// reset clears valid flags and keystream state and returns configuration to its defaults
`default_nettype none
module running_shift_vigenere_cipher_unit #(
  parameter int unsigned MAX_KEY_LEN = 24
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  rvc_in_if.sink                              in_i,
  rvc_out_if.source                           out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [rvc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rvc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  rvc_pkg::cfg_t      cfg;
  rvc_pkg::ks_state_t ks_q, ks_d;

  logic                       s1_valid_q, s1_start_q;
  logic [rvc_pkg::CHAR_W-1:0] s1_char_q;
  logic                       out_valid_q;
  logic [rvc_pkg::CHAR_W-1:0] out_char_q, out_char_d;
  logic                       out_free, s1_adv, in_acc;

  rvc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rvc_xform #(.MAX_KEY_LEN(MAX_KEY_LEN)) u_xform (
    .char_i  (s1_char_q),
    .start_i (s1_start_q),
    .cfg_i   (cfg),
    .state_i (ks_q),
    .char_o  (out_char_d),
    .state_o (ks_d)
  );

  assign out_free    = !out_valid_q || out_o.ready;
  assign s1_adv      = s1_valid_q && out_free;
  assign in_i.ready  = !s1_valid_q || out_free;
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.char_out = out_char_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ks_q        <= '0;
    end else begin
      if (in_acc)        s1_valid_q <= 1'b1;
      else if (s1_adv)   s1_valid_q <= 1'b0;
      if (s1_adv)        out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      if (s1_adv)        ks_q <= ks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_char_q  <= in_i.char_in;
      s1_start_q <= in_i.start_of_message;
    end
    if (s1_adv) begin
      out_char_q <= out_char_d;
    end
  end

  a_in_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted beat did not reach the input register");

  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q && out_char_q == $past(out_char_d))
    else $error("advanced beat did not land in the result register");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> s1_valid_q && $stable(s1_char_q) && $stable(s1_start_q))
    else $error("input register lost a stalled beat");

  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> ks_q.running_shift < 5'd26 && ks_q.position_mod < 5'd26)
    else $error("keystream state left the alphabet range");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(ks_q))
    else $error("keystream state moved without a beat");

endmodule
`default_nettype wire
